FILE: design/lru_page_replacement_macros.svh
// Assertion macros shared by the LRU page replacement RTL.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing when SYNTH is defined.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold on that edge.
`define LRUPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru page replacement check failed");
// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru page replacement check failed");
`else
`define LRUPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned FILL_W   = 4;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned CFG_W    = 4;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // Sequencer states: wait for a reference, walk the LRU search down the
  // chain, then commit the update and the result.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic clear;   // drop all recency ranks (start of a new run)
    logic touch;   // apply the recency update for the selected slot
    logic wr;      // also load the new page into the selected slot
  } lrupr_cell_ctl_t;

  // Handshake-side control from the sequencer.
  typedef struct packed {
    logic in_ready;
    logic commit;
  } lrupr_phase_t;

endpackage

`default_nettype wire

FILE: design/lrupr_in_if.sv
`default_nettype none

interface lrupr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] page;
  logic       start_new;

  modport source (output valid, output page, output start_new, input ready);
  modport sink   (input valid, input page, input start_new, output ready);
endinterface

`default_nettype wire

FILE: design/lrupr_out_if.sv
`default_nettype none

interface lrupr_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  slot;
  logic [3:0]  filled;
  logic [15:0] fault_total;
  logic [15:0] hit_total;

  modport source (output valid, output hit, output slot, output filled,
                  output fault_total, output hit_total, input ready);
  modport sink   (input valid, input hit, input slot, input filled,
                  input fault_total, input hit_total, output ready);
endinterface

`default_nettype wire

FILE: design/lrupr_cell.sv
`default_nettype none

module lrupr_cell #(
  parameter int unsigned FRAMES = 8,
  parameter int unsigned IDX    = 0,
  localparam int unsigned RW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int unsigned CW = $clog2(FRAMES + 1)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  lrupr_pkg::lrupr_cell_ctl_t ctl,
  input  wire [7:0]                  page,
  input  wire [SW-1:0]               slot,
  input  wire [CW-1:0]               old_rank,
  input  wire [CW-1:0]               filled,
  input  wire [CW-1:0]               filled_new,
  input  wire [CW-1:0]               lim,
  input  wire                        scan_has_in,
  input  wire [RW-1:0]               scan_rank_in,
  input  wire [SW-1:0]               scan_idx_in,
  output logic                       scan_has_out,
  output logic [RW-1:0]              scan_rank_out,
  output logic [SW-1:0]              scan_idx_out,
  output logic                       match,
  output logic [RW-1:0]              rank
);
  import lrupr_pkg::*;

  logic [7:0]    page_r;
  logic [RW-1:0] rank_r;
  logic [RW-1:0] rank_nxt;
  logic          sel;
  logic          in_lim;
  logic          take;

  assign sel    = (slot == SW'(IDX));
  assign in_lim = (CW'(IDX) < lim);
  assign match  = (CW'(IDX) < filled) && (page_r == page);
  assign rank   = rank_r;

  // Frames younger than the touched frame age by one; the touched frame
  // becomes most recent.
  always_comb begin
    rank_nxt = rank_r;
    if (ctl.clear) begin
      rank_nxt = '0;
    end else if (ctl.touch) begin
      if (sel) begin
        rank_nxt = '0;
      end else if ((CW'(IDX) < filled_new) && (CW'(rank_r) < old_rank)) begin
        rank_nxt = RW'(rank_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else begin
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.touch && ctl.wr && sel) begin
      page_r <= page;
    end
  end

  // One stage of the oldest-frame search; the first strictly older frame wins.
  assign take = in_lim && (!scan_has_in || (rank_r > scan_rank_in));

  always_ff @(posedge clk) begin
    scan_has_out  <= scan_has_in || in_lim;
    scan_rank_out <= take ? rank_r : scan_rank_in;
    scan_idx_out  <= take ? SW'(IDX) : scan_idx_in;
  end

endmodule

`default_nettype wire

FILE: design/lrupr_ctrl.sv
`default_nettype none
`include "lru_page_replacement_macros.svh"

module lrupr_ctrl #(
  parameter int unsigned FRAMES = 8
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_fire,
  input  wire                     out_free,
  output lrupr_pkg::lrupr_phase_t phase
);
  import lrupr_pkg::*;

  localparam int unsigned NW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [NW-1:0] LAST_CNT = NW'(FRAMES - 1);

  lrupr_state_t  state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = NW'(cnt_r + 1'b1);
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    phase = '0;
    case (state_r)
      ST_IDLE:   phase.in_ready = 1'b1;
      ST_UPDATE: phase.commit   = out_free;
      default:   phase = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `LRUPR_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_fire, !phase.in_ready)
  `LRUPR_ASSERT_IMPL(a_full_scan, clk, rst_n, $rose(state_r == ST_UPDATE), $past(cnt_r) == LAST_CNT)

endmodule

`default_nettype wire

FILE: design/lru_page_replacement.sv
// Sequencing: an accepted reference beat moves the block from IDLE to SCAN, which
// covers the oldest-frame search that moves one cell down the chain per cycle,
// then to UPDATE; a new reference is taken only after the commit, back in IDLE.
// Reset (rst_n, synchronous, active low): clears ranks, fill count, totals and
// the result valid flag, and sets the frame limit to 3; frame pages are not cleared.
`default_nettype none
`include "lru_page_replacement_macros.svh"

module lru_page_replacement #(
  parameter int unsigned FRAMES = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  lrupr_in_if.sink              in_ch,
  lrupr_out_if.source           out_ch,
  input  wire                   cfg_we,
  input  wire [3:0]             cfg_wdata
);
  import lrupr_pkg::*;

  // Widths that follow from the frame count. A rank and a slot index need
  // log2(FRAMES) bits; counts and the limit must also hold FRAMES itself.
  localparam int unsigned RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

  // Configuration register: the number of frames that may take new pages.
  logic [CFG_W-1:0] cfg_r;
  logic [CW-1:0]    lim;

  // Block state outside the cells.
  logic [CW-1:0]      filled_r, filled_nxt;
  logic [TOTAL_W-1:0] fault_r, fault_nxt;
  logic [TOTAL_W-1:0] hits_r, hits_nxt;
  logic [PAGE_W-1:0]  page_r;

  // Result register, which lets a new reference be taken while a result waits.
  logic               out_valid_r, out_valid_nxt;
  logic               res_hit_r;
  logic [SLOT_W-1:0]  res_slot_r;
  logic [FILL_W-1:0]  res_filled_r;
  logic [TOTAL_W-1:0] res_fault_r;
  logic [TOTAL_W-1:0] res_hits_r;

  lrupr_phase_t    phase;
  lrupr_cell_ctl_t cell_ctl;
  logic            in_fire;
  logic            out_free;

  // Per-cell outputs and the search chain; stage 0 is the empty seed.
  logic [FRAMES-1:0] match;
  logic [RW-1:0]     cell_rank [FRAMES];
  logic              scan_has  [FRAMES+1];
  logic [RW-1:0]     scan_rank [FRAMES+1];
  logic [SW-1:0]     scan_idx  [FRAMES+1];

  logic          found;
  logic          fill;
  logic [SW-1:0] hit_idx;
  logic [RW-1:0] hit_rank;
  logic [SW-1:0] slot_sel;
  logic [CW-1:0] old_rank;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = phase.in_ready;

  lrupr_ctrl #(.FRAMES(FRAMES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .phase    (phase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // A limit of zero acts as one frame, and a limit above FRAMES saturates.
  always_comb begin
    if (cfg_r == '0) begin
      lim = CW'(1);
    end else if (LW'(cfg_r) > LW'(FRAMES)) begin
      lim = CW'(FRAMES);
    end else begin
      lim = CW'(cfg_r);
    end
  end

  // The page is held for the whole search. A start flag clears the ranks,
  // the fill count and the totals on the accepting edge, so the search that
  // follows already sees the emptied set.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r <= in_ch.page;
    end
  end

  assign scan_has[0]  = 1'b0;
  assign scan_rank[0] = '0;
  assign scan_idx[0]  = '0;

  for (genvar j = 0; j < FRAMES; j++) begin : g_cell
    lrupr_cell #(.FRAMES(FRAMES), .IDX(j)) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (cell_ctl),
      .page          (page_r),
      .slot          (slot_sel),
      .old_rank      (old_rank),
      .filled        (filled_r),
      .filled_new    (filled_nxt),
      .lim           (lim),
      .scan_has_in   (scan_has[j]),
      .scan_rank_in  (scan_rank[j]),
      .scan_idx_in   (scan_idx[j]),
      .scan_has_out  (scan_has[j+1]),
      .scan_rank_out (scan_rank[j+1]),
      .scan_idx_out  (scan_idx[j+1]),
      .match         (match[j]),
      .rank          (cell_rank[j])
    );
  end

  // Filled frames hold distinct pages, so at most one cell matches and the
  // index and rank of the hit can be gathered with a plain OR.
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int j = 0; j < FRAMES; j++) begin
      if (match[j]) begin
        hit_idx  = hit_idx | SW'(j);
        hit_rank = hit_rank | cell_rank[j];
      end
    end
  end

  assign found = |match;
  assign fill  = !found && (filled_r < lim);

  // Pick the frame to touch. A hit refreshes its own frame. A miss fills the
  // next empty frame while the limit allows, and it then counts as older than
  // every frame so all filled frames age. Otherwise the oldest frame among
  // the first lim frames, found by the chain search, is replaced.
  always_comb begin
    if (found) begin
      slot_sel = hit_idx;
      old_rank = CW'(hit_rank);
    end else if (fill) begin
      slot_sel = SW'(filled_r);
      old_rank = CW'(FRAMES);
    end else begin
      slot_sel = scan_idx[FRAMES];
      old_rank = CW'(scan_rank[FRAMES]);
    end
  end

  always_comb begin
    cell_ctl.clear = in_fire && in_ch.start_new;
    cell_ctl.touch = phase.commit;
    cell_ctl.wr    = phase.commit && !found;
  end

  // Fill count and saturating totals.
  always_comb begin
    filled_nxt = filled_r;
    fault_nxt  = fault_r;
    hits_nxt   = hits_r;
    if (phase.commit) begin
      if (fill) begin
        filled_nxt = CW'(filled_r + 1'b1);
      end
      if (found) begin
        if (hits_r != TOTAL_MAX) begin
          hits_nxt = hits_r + 1'b1;
        end
      end else if (fault_r != TOTAL_MAX) begin
        fault_nxt = fault_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      fault_r  <= '0;
      hits_r   <= '0;
    end else if (in_fire && in_ch.start_new) begin
      filled_r <= '0;
      fault_r  <= '0;
      hits_r   <= '0;
    end else begin
      filled_r <= filled_nxt;
      fault_r  <= fault_nxt;
      hits_r   <= hits_nxt;
    end
  end

  // Result register. A commit only happens when the register is free or
  // being emptied on the same edge.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (phase.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result fields, totals included, are captured on the commit edge and
  // held unchanged while the beat waits for the sink.
  always_ff @(posedge clk) begin
    if (phase.commit) begin
      res_hit_r    <= found;
      res_slot_r   <= SLOT_W'(slot_sel);
      res_filled_r <= FILL_W'(filled_nxt);
      res_fault_r  <= fault_nxt;
      res_hits_r   <= hits_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = res_hit_r;
  assign out_ch.slot        = res_slot_r;
  assign out_ch.filled      = res_filled_r;
  assign out_ch.fault_total = res_fault_r;
  assign out_ch.hit_total   = res_hits_r;

  `LRUPR_ASSERT_IMPL(a_match_unique, clk, rst_n, 1'b1, $onehot0(match))
  `LRUPR_ASSERT_NEXT(a_hit_keeps_fill, clk, rst_n, phase.commit && found, filled_r == $past(filled_r))

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  // The block is built with its default of eight frames.
  localparam int FRAMES = 8;
  // Longest stretch with no beat on any port that a correct run can show.
  // This covers the longest send gap, the search and the longest receive stall
  // back to back, plus the pause before a register write.
  localparam int QUIET_LIMIT = 1000;

  // One page reference as it travels on the input channel.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              start_new;
  } page_ref_t;

  // What one reference is expected to report.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [FILL_W-1:0]  filled;
    logic [TOTAL_W-1:0] fault_total;
    logic [TOTAL_W-1:0] hit_total;
  } lru_outcome_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lrupr_in_if  in_bus ();
  lrupr_out_if out_bus ();

  lru_page_replacement #(
    .FRAMES(FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // References waiting to be driven, and outcomes waiting to come back.
  page_ref_t    ref_backlog[$];
  lru_outcome_t outcome_fifo[$];

  // Shadow copy of the frame table. Recency rank 0 is the most recently
  // used frame; filled frames always hold the ranks 0 .. used_frames-1.
  logic [PAGE_W-1:0]  held_page[FRAMES];
  int                 frame_rank[FRAMES];
  int                 used_frames;
  logic [TOTAL_W-1:0] fault_tally;
  logic [TOTAL_W-1:0] hit_tally;
  logic [CFG_W-1:0]   limit_reg;

  // Bookkeeping shared by the driver, the monitor and the stimulus.
  int unsigned  issued;
  int unsigned  retired;
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int           send_gap;
  int           recv_stall;
  bit           calm;
  page_ref_t    next_ref;
  lru_outcome_t got_outcome;
  lru_outcome_t want_outcome;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle cycles a side spends before its next beat. Calm phases run with
  // both sides always ready so the block sees back-to-back traffic.
  function automatic int draw_idle();
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Makes slot s the most recent frame. Filled frames that were more recent
  // than its old rank move one step older.
  function automatic void promote(int s, int old_rank);
    for (int j = 0; j < used_frames && j < FRAMES; j++) begin
      if (j != s && frame_rank[j] < old_rank) begin
        frame_rank[j] = frame_rank[j] + 1;
      end
    end
    frame_rank[s] = 0;
  endfunction

  // Applies one reference to the shadow frame table and returns what the
  // block should report for it.
  function automatic lru_outcome_t lru_lookup(logic [PAGE_W-1:0] pg, logic fresh);
    lru_outcome_t res;
    int           lim;
    int           s;
    int           victim;
    bit           found;

    if (fresh) begin
      for (int j = 0; j < FRAMES; j++) begin
        held_page[j]  = '0;
        frame_rank[j] = 0;
      end
      used_frames = 0;
      fault_tally = '0;
      hit_tally   = '0;
    end

    // A limit of zero acts as one frame, and anything above the frame
    // count saturates to it.
    lim = int'(limit_reg);
    if (lim == 0) begin
      lim = 1;
    end
    if (lim > FRAMES) begin
      lim = FRAMES;
    end

    // Only filled frames take part in the compare, so a frame that was
    // never loaded is never looked at.
    found = 1'b0;
    s     = 0;
    for (int j = 0; j < used_frames && j < FRAMES; j++) begin
      if (!found && held_page[j] == pg) begin
        found = 1'b1;
        s     = j;
      end
    end

    if (found) begin
      promote(s, frame_rank[s]);
      if (hit_tally != TOTAL_MAX) begin
        hit_tally = hit_tally + 1'b1;
      end
    end else begin
      if (used_frames < lim) begin
        // A fresh frame starts older than everything else.
        s            = used_frames;
        held_page[s] = pg;
        used_frames  = used_frames + 1;
        promote(s, FRAMES);
      end else begin
        // Evict the oldest frame among 0 .. lim-1. When the limit was
        // lowered below the fill count, frames above it stay resident but
        // are never chosen here.
        victim = 0;
        for (int j = 1; j < lim; j++) begin
          if (frame_rank[j] > frame_rank[victim]) begin
            victim = j;
          end
        end
        s            = victim;
        held_page[s] = pg;
        promote(s, frame_rank[s]);
      end
      if (fault_tally != TOTAL_MAX) begin
        fault_tally = fault_tally + 1'b1;
      end
    end

    res.hit         = found;
    res.slot        = s[SLOT_W-1:0];
    res.filled      = used_frames[FILL_W-1:0];
    res.fault_total = fault_tally;
    res.hit_total   = hit_tally;
    return res;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  // Driver. A beat that is not yet accepted stays on the bus untouched. Once
  // it is accepted its outcome is predicted, and the next reference goes out
  // after the idle count that was drawn for it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid     <= 1'b0;
      in_bus.page      <= '0;
      in_bus.start_new <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        outcome_fifo.push_back(lru_lookup(in_bus.page, in_bus.start_new));
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (ref_backlog.size() != 0) begin
          next_ref = ref_backlog.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.page      <= next_ref.page;
          in_bus.start_new <= next_ref.start_new;
          issued++;
          send_gap = draw_idle();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result beat is checked field by field against the oldest
  // prediction. After a beat, ready drops for the stall drawn for the next
  // result, so stalls land on every phase of the block's search.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_outcome.hit         = out_bus.hit;
        got_outcome.slot        = out_bus.slot;
        got_outcome.filled      = out_bus.filled;
        got_outcome.fault_total = out_bus.fault_total;
        got_outcome.hit_total   = out_bus.hit_total;
        if (outcome_fifo.size() == 0) begin
          flag_mismatch("unexpected result", 1, 0);
        end else begin
          want_outcome = outcome_fifo.pop_front();
          if (got_outcome.hit !== want_outcome.hit) begin
            flag_mismatch("hit", got_outcome.hit, want_outcome.hit);
          end
          if (got_outcome.slot !== want_outcome.slot) begin
            flag_mismatch("slot", got_outcome.slot, want_outcome.slot);
          end
          if (got_outcome.filled !== want_outcome.filled) begin
            flag_mismatch("filled", got_outcome.filled, want_outcome.filled);
          end
          if (got_outcome.fault_total !== want_outcome.fault_total) begin
            flag_mismatch("fault_total", got_outcome.fault_total, want_outcome.fault_total);
          end
          if (got_outcome.hit_total !== want_outcome.hit_total) begin
            flag_mismatch("hit_total", got_outcome.hit_total, want_outcome.hit_total);
          end
        end
        retired++;
        recv_stall = draw_idle();
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Counts cycles in which no beat moves on any port.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_ref(logic [PAGE_W-1:0] pg, logic fresh);
    page_ref_t r;
    r.page      = pg;
    r.start_new = fresh;
    ref_backlog.push_back(r);
  endtask

  // Holds off until every reference has been sent and answered, then lets
  // the search latency pass, so a register write never lands mid-search.
  task automatic wait_drained();
    while (ref_backlog.size() != 0 || issued != retired) begin
      @(posedge clk);
    end
    repeat (FRAMES + 4) @(posedge clk);
  endtask

  // Writes the frame limit while the block is idle and updates the shadow.
  task automatic program_limit(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
  endtask

  // One random phase. Most references come from a small working set a bit
  // larger than the active limit, so hits, fills and evictions all happen;
  // the rest are pages from the whole range. A few restart the run.
  task automatic queue_random_phase(int count, int working_set);
    int base;
    base = $urandom_range(0, 255 - working_set);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        push_ref(8'(base + $urandom_range(0, working_set - 1)), $urandom_range(0, 39) == 0);
      end else begin
        push_ref(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
      end
    end
  endtask

  initial begin
    int           plan[8];
    int           lim;
    logic [3:0]   setting;

    plan        = '{1, 8, 15, 0, 2, 5, 3, 7};
    issued      = 0;
    retired     = 0;
    mismatches  = 0;
    calm        = 1'b0;
    used_frames = 0;
    fault_tally = '0;
    hit_tally   = '0;
    limit_reg   = CFG_RESET;
    cfg_we      = 1'b0;
    cfg_wdata   = CFG_RESET;
    for (int j = 0; j < FRAMES; j++) begin
      held_page[j]  = '0;
      frame_rank[j] = 0;
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First the limit as it comes out of reset: the extreme
    // pages, a hit, a fill up to the limit and two evictions.
    push_ref(8'h00, 1'b1);
    push_ref(8'hFF, 1'b0);
    push_ref(8'h00, 1'b0);
    push_ref(8'h80, 1'b0);
    push_ref(8'h7F, 1'b0);
    push_ref(8'hFF, 1'b0);
    wait_drained();

    // A limit above the frame count saturates to it: fill all frames,
    // evict the oldest, then hit.
    program_limit(4'd15);
    push_ref(8'd1, 1'b1);
    for (int p = 2; p <= 9; p++) begin
      push_ref(8'(p), 1'b0);
    end
    push_ref(8'd8, 1'b0);
    wait_drained();

    // Limit lowered below the fill count: frames above the limit still hit,
    // misses evict only among the first two frames.
    program_limit(4'd2);
    push_ref(8'd5, 1'b0);
    push_ref(8'd200, 1'b0);
    push_ref(8'd201, 1'b0);
    push_ref(8'd7, 1'b0);
    wait_drained();

    // A zero limit acts as a single frame.
    program_limit(4'd0);
    push_ref(8'd33, 1'b1);
    push_ref(8'd33, 1'b0);
    push_ref(8'd34, 1'b0);
    wait_drained();

    // Random part: eleven phases, each behind its own limit write. Every
    // phase boundary also makes the sender wait until all results are in.
    for (int ph = 0; ph < 11; ph++) begin
      if (ph < 8) begin
        setting = 4'(plan[ph]);
      end else begin
        setting = 4'($urandom_range(0, 15));
      end
      program_limit(setting);
      lim = int'(setting);
      if (lim == 0) begin
        lim = 1;
      end
      if (lim > FRAMES) begin
        lim = FRAMES;
      end
      calm = (ph % 3 == 0);
      queue_random_phase(103, lim + $urandom_range(1, 3));
      wait_drained();
    end

    if (outcome_fifo.size() != 0) begin
      flag_mismatch("outcomes never returned", 0, outcome_fifo.size());
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/lrupr_pkg.sv
design/lrupr_in_if.sv
design/lrupr_out_if.sv
design/lrupr_cell.sv
design/lrupr_ctrl.sv
design/lru_page_replacement.sv
bench/testbench.sv
